### rtl/pib_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette index bit packer package
// Shared constants, the front-to-back operation type and the entry width
// function.
// ----------------------------------------------------------------------------
package pib_pkg;

	localparam int unsigned SECTION_BLOCKS_DEF = 4096;
	localparam int unsigned WORD_BITS_DEF      = 64;
	localparam int unsigned MIN_ENTRY_BITS_DEF = 4;

	localparam int unsigned WORD_BITS_MAX = 64;
	localparam int unsigned PCOUNT_W      = 13;
	localparam int unsigned INDEX_W       = 12;
	localparam int unsigned EWIDTH_W      = 4;
	localparam int unsigned OFFSET_W      = $clog2(WORD_BITS_MAX);
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(2);

	typedef struct packed {
		logic [INDEX_W-1:0]  entry;
		logic [OFFSET_W-1:0] offset;
		logic                emit;
		logic                last;
	} op_t;

	function automatic logic [EWIDTH_W-1:0] entry_width(
		input logic [PCOUNT_W-1:0] count,
		input int unsigned         min_bits
	);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if ((17'd1 << i) < {4'b0000, count}) begin
				n = n + 5'd1;
			end
		end
		if (n < 5'(min_bits)) begin
			n = 5'(min_bits);
		end
		return n[EWIDTH_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/pib_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette index bit packer operation queue
// Small register FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module pib_queue #(
	parameter int unsigned DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output logic [DATA_W-1:0]      pop_data
);

	localparam int unsigned DEPTH = pib_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");
	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count did not follow a write");

endmodule
`default_nettype wire

### rtl/pib_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette index bit packer front
// Accepts palette indices, masks them to the entry width and classifies each
// item by bit offset, word end and section end.
// ----------------------------------------------------------------------------
module pib_front #(
	parameter int unsigned SECTION_BLOCKS = pib_pkg::SECTION_BLOCKS_DEF,
	parameter int unsigned WORD_BITS      = pib_pkg::WORD_BITS_DEF,
	parameter int unsigned MIN_ENTRY_BITS = pib_pkg::MIN_ENTRY_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [pib_pkg::PCOUNT_W-1:0] palette_count,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [pib_pkg::INDEX_W-1:0]  palette_index,
	input  wire logic                         queue_full,
	output logic                              push,
	output pib_pkg::op_t                      push_op
);

	localparam int unsigned OFF_W = $clog2(WORD_BITS);
	localparam int unsigned SUM_W = OFF_W + 1;
	localparam int unsigned CNT_W = $clog2(SECTION_BLOCKS);

	logic [pib_pkg::EWIDTH_W-1:0] width_q;
	logic [OFF_W-1:0]             off_q;
	logic [CNT_W-1:0]             blocks_q;
	logic [pib_pkg::INDEX_W-1:0]  entry;
	logic [SUM_W-1:0]             next_off;
	logic                         word_full;
	logic                         section_end;

	always_comb begin
		for (int i = 0; i < pib_pkg::INDEX_W; i++) begin
			entry[i] = palette_index[i] & (pib_pkg::EWIDTH_W'(i) < width_q);
		end
	end

	assign next_off    = SUM_W'(off_q) + SUM_W'(width_q);
	assign word_full   = (next_off + SUM_W'(width_q)) > SUM_W'(WORD_BITS);
	assign section_end = (blocks_q == CNT_W'(SECTION_BLOCKS - 1));

	assign in_stall       = queue_full;
	assign push           = in_valid && !queue_full;
	assign push_op.entry  = entry;
	assign push_op.offset = pib_pkg::OFFSET_W'(off_q);
	assign push_op.emit   = word_full || section_end;
	assign push_op.last   = section_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pib_pkg::entry_width(pib_pkg::PCOUNT_RESET, MIN_ENTRY_BITS);
			off_q    <= '0;
			blocks_q <= '0;
		end else if (cfg_write) begin
			width_q  <= pib_pkg::entry_width(palette_count, MIN_ENTRY_BITS);
			off_q    <= '0;
			blocks_q <= '0;
		end else if (push) begin
			off_q    <= push_op.emit ? '0 : next_off[OFF_W-1:0];
			blocks_q <= section_end ? '0 : blocks_q + CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

### rtl/pib_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette index bit packer back
// Merges queued entries into the word accumulator and hands full words, and the
// final word of each section, to the output register.
// ----------------------------------------------------------------------------
module pib_back #(
	parameter int unsigned WORD_BITS = pib_pkg::WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic                 not_empty,
	input  wire pib_pkg::op_t         pop_op,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [WORD_BITS-1:0]      packed_word,
	output logic                      last_word
);

	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] packed_word_q;
	logic                 last_word_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] merged;
	logic                 out_free;
	logic                 load;

	assign merged   = acc_q | (WORD_BITS'(pop_op.entry) << pop_op.offset);
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = not_empty && (!pop_op.emit || out_free);
	assign load     = pop && pop_op.emit;

	assign out_valid   = out_valid_q;
	assign packed_word = packed_word_q;
	assign last_word   = last_word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			packed_word_q <= merged;
			last_word_q   <= pop_op.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write || load) begin
				acc_q <= '0;
			end else if (pop) begin
				acc_q <= merged;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/palette_index_bit_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Palette index bit packer
// Packs a section's palette indices into fixed-width words, first entry at
// bit zero, with the final word of each section padded and marked last.
// ----------------------------------------------------------------------------
// The block takes one palette index per cycle and keeps that rate as long as
// the output side is not stalled. The item that completes a result word is
// classified and written into a four-deep queue in the accept cycle; when it
// reaches the queue head, the back end merges it with the accumulator and
// registers the word for output. The entry width follows the palette count
// and is updated by a write on the configuration channel, which also starts a
// new section; write it only while no items are in flight.
module palette_index_bit_packer #(
	parameter int unsigned SECTION_BLOCKS = pib_pkg::SECTION_BLOCKS_DEF,
	parameter int unsigned WORD_BITS      = pib_pkg::WORD_BITS_DEF,
	parameter int unsigned MIN_ENTRY_BITS = pib_pkg::MIN_ENTRY_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [pib_pkg::PCOUNT_W-1:0] palette_count,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [pib_pkg::INDEX_W-1:0]  palette_index,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [WORD_BITS-1:0]              packed_word,
	output logic                              last_word
);

	localparam int unsigned OP_W = $bits(pib_pkg::op_t);

	logic         cfg_write;
	logic         push;
	pib_pkg::op_t push_op;
	logic         queue_full;
	logic         pop;
	logic         not_empty;
	pib_pkg::op_t pop_op;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	pib_front #(
		.SECTION_BLOCKS(SECTION_BLOCKS),
		.WORD_BITS(WORD_BITS),
		.MIN_ENTRY_BITS(MIN_ENTRY_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.palette_count(palette_count),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.palette_index(palette_index),
		.queue_full(queue_full),
		.push(push),
		.push_op(push_op)
	);

	pib_queue #(
		.DATA_W(OP_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_op),
		.full(queue_full),
		.pop(pop),
		.not_empty(not_empty),
		.pop_data(pop_op)
	);

	pib_back #(
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.not_empty(not_empty),
		.pop_op(pop_op),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packed_word(packed_word),
		.last_word(last_word)
	);

endmodule
`default_nettype wire
